// File: rtl/tws_pkg.sv
// Shared constants and types for the trie word store.
// Sizes of the node pool and child table, and the action codes of a request.
// No dependencies.
`timescale 1ns / 1ps

package tws_pkg;

   // Node pool and alphabet sizes.
   localparam int NODES    = 4096;
   localparam int ALPHABET = 26;

   // Derived widths.
   localparam int NODE_W   = $clog2(NODES);
   localparam int COUNT_W  = $clog2(NODES + 1);
   localparam int ADDR_W   = $clog2(NODES * ALPHABET);
   localparam int IDX_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int LETTER_W = 5;
   localparam int ACTION_W = 2;

   // Action codes carried by a request.
   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_FIND   = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

endpackage

// File: rtl/trie_word_store_top.sv
// Trie word store: one letter per request, insert/find/clear over a node pool.
// The child table and end marks are on-chip memories; one multiply-add address unit
// is shared by lookups, child writes and row blanking. Depends on tws_pkg.
// Steps: a letter is read from the child table (S_READ) and checked (S_LOOK); allocating a node
// then blanks its row of ALPHABET (26) entries in S_BLANK, one table-port write per cycle.
// The last letter of a word then reads the end mark (S_MARK_RD) before the response (S_END).
// Throughput: one request at a time; request ready only while the sequencer is idle.
// Reset (synchronous): root row valid bits, cursor and flags cleared, node count set to one.
`timescale 1ns / 1ps

module trie_word_store_top
   import tws_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic                rsp_full_res
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LOOK,
      S_BLANK,
      S_MARK_RD,
      S_END
   } state_type;

   // Memories.
   logic [NODE_W-1:0]   child_mem [NODES*ALPHABET];
   logic                mark_mem  [NODES];
   logic [NODE_W-1:0]   child_rd_ff;
   logic                mark_rd_ff;

   // Control and walk state.
   state_type           state_ff, state_in;
   logic [ALPHABET-1:0] root_valid_ff, root_valid_in;
   logic [COUNT_W-1:0]  node_count_ff, node_count_in;
   logic [NODE_W-1:0]   cursor_ff, cursor_in;
   logic                miss_ff, miss_in;
   logic                overflow_ff, overflow_in;
   logic [IDX_W-1:0]    blank_idx_ff, blank_idx_in;
   action_type          action_ff, action_in;
   logic [LETTER_W-1:0] letter_ff, letter_in;
   logic                last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_full_ff, rsp_full_in;

   // Datapath signals.
   logic [ADDR_W-1:0]   table_addr;
   logic [IDX_W-1:0]    letter_idx;
   logic [IDX_W-1:0]    addr_idx;
   logic [NODE_W-1:0]   child;
   logic [NODE_W-1:0]   new_node;
   logic                alloc;
   logic                table_we;
   logic [NODE_W-1:0]   table_wdata;
   logic                mark_we;
   logic [NODE_W-1:0]   mark_waddr;
   logic                mark_wdata;
   logic                req_take;
   logic                letter_bad;
   logic                rsp_free;
   state_type           after_letter;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_take     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_full_res = rsp_full_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   assign letter_bad   = ({1'b0, req_letter} >= (LETTER_W + 1)'(ALPHABET));
   assign letter_idx   = IDX_W'(letter_ff);
   assign new_node     = node_count_ff[NODE_W-1:0];
   assign after_letter = last_ff ? S_MARK_RD : S_IDLE;

   // Shared address unit: row base of the cursor plus the letter or blanking index.
   assign addr_idx   = (state_ff == S_BLANK) ? blank_idx_ff : letter_idx;
   assign table_addr = ADDR_W'(cursor_ff) * ADDR_W'(ALPHABET) + ADDR_W'(addr_idx);

   // The root row reads as empty until each entry has been written since clear.
   assign child = ((cursor_ff == '0) && !root_valid_ff[letter_idx]) ? '0 : child_rd_ff;

   // A missing child on insert allocates when the pool has room.
   assign alloc = (state_ff == S_LOOK) && (action_ff == ACT_INSERT) && (child == '0)
                  && (node_count_ff < COUNT_W'(NODES));

   // Memory write controls.
   always_comb begin
      table_we    = 1'b0;
      table_wdata = '0;
      mark_we     = 1'b0;
      mark_waddr  = cursor_ff;
      mark_wdata  = 1'b0;
      if (alloc) begin
         table_we    = 1'b1;
         table_wdata = new_node;
         mark_we     = 1'b1;
         mark_waddr  = new_node;
      end else if (state_ff == S_BLANK) begin
         table_we    = 1'b1;
      end else if ((state_ff == S_END) && rsp_free && (action_ff == ACT_INSERT)
                   && !overflow_ff) begin
         mark_we     = 1'b1;
         mark_wdata  = 1'b1;
      end
   end

   // Child table memory with registered read.
   always_ff @(posedge clock) begin
      if (table_we) begin
         child_mem[table_addr] <= table_wdata;
      end
      if (state_ff == S_READ) begin
         child_rd_ff <= child_mem[table_addr];
      end
   end

   // End-mark memory with registered read.
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (state_ff == S_MARK_RD) begin
         mark_rd_ff <= mark_mem[cursor_ff];
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      root_valid_in = root_valid_ff;
      node_count_in = node_count_ff;
      cursor_in     = cursor_ff;
      miss_in       = miss_ff;
      overflow_in   = overflow_ff;
      blank_idx_in  = blank_idx_ff;
      action_in     = action_ff;
      letter_in     = letter_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_full_in   = rsp_full_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               action_in = action_type'(req_action);
               letter_in = req_letter;
               last_in   = req_last;
               unique case (action_type'(req_action))
                  ACT_CLEAR: begin
                     root_valid_in = '0;
                     node_count_in = COUNT_W'(1);
                     cursor_in     = '0;
                     miss_in       = 1'b0;
                     overflow_in   = 1'b0;
                  end
                  ACT_INSERT: begin
                     if (overflow_ff) begin
                        state_in = req_last ? S_MARK_RD : S_IDLE;
                     end else if (letter_bad) begin
                        overflow_in = 1'b1;
                        state_in    = req_last ? S_MARK_RD : S_IDLE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  ACT_FIND: begin
                     if (miss_ff || overflow_ff || letter_bad) begin
                        miss_in  = 1'b1;
                        state_in = req_last ? S_MARK_RD : S_IDLE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            if (child != '0) begin
               cursor_in = child;
               state_in  = after_letter;
            end else if (action_ff == ACT_FIND) begin
               miss_in  = 1'b1;
               state_in = after_letter;
            end else if (alloc) begin
               if (cursor_ff == '0) begin
                  root_valid_in[letter_idx] = 1'b1;
               end
               node_count_in = node_count_ff + COUNT_W'(1);
               cursor_in     = new_node;
               miss_in       = 1'b1;
               blank_idx_in  = '0;
               state_in      = S_BLANK;
            end else begin
               overflow_in = 1'b1;
               state_in    = after_letter;
            end
         end
         S_BLANK: begin
            if (blank_idx_ff == IDX_W'(ALPHABET - 1)) begin
               state_in = after_letter;
            end else begin
               blank_idx_in = blank_idx_ff + IDX_W'(1);
            end
         end
         S_MARK_RD: begin
            state_in = S_END;
         end
         S_END: begin
            // Hold the result until the output register is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (action_ff == ACT_INSERT && overflow_ff) begin
                  rsp_found_in = 1'b0;
                  rsp_full_in  = 1'b1;
               end else begin
                  rsp_found_in = !miss_ff && mark_rd_ff;
                  rsp_full_in  = 1'b0;
               end
               cursor_in   = '0;
               miss_in     = 1'b0;
               overflow_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_valid_ff <= '0;
         node_count_ff <= COUNT_W'(1);
         cursor_ff     <= '0;
         miss_ff       <= 1'b0;
         overflow_ff   <= 1'b0;
         blank_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_valid_ff <= root_valid_in;
         node_count_ff <= node_count_in;
         cursor_ff     <= cursor_in;
         miss_ff       <= miss_in;
         overflow_ff   <= overflow_in;
         blank_idx_ff  <= blank_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      action_ff    <= action_in;
      letter_ff    <= letter_in;
      last_ff      <= last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

endmodule

// File: bench/trie_word_store_top_tb.sv
// Self-checking bench for trie_word_store_top: directed letter requests and random
// word traffic, checked against a trie model kept in the bench or results given per row.
// Depends on tws_pkg and the trie_word_store_top RTL.
`timescale 1ns / 1ps

module trie_word_store_top_tb;
   import tws_pkg::*;

   localparam int MAX_WORD       = 48;
   localparam int VOCAB_SIZE     = 64;
   localparam int RANDOM_LETTERS = 1200;
   localparam int DIR_ROWS       = 23;

   // Receiver stall patterns.
   localparam int STALL_NONE   = 0;
   localparam int STALL_COIN   = 1;
   localparam int STALL_SPARSE = 2;

   typedef struct packed {
      logic found;
      logic full_res;
   } word_result_type;

   // One directed request; a given result replaces the model's where it is obvious.
   typedef struct packed {
      action_type          act;
      logic [LETTER_W-1:0] ltr;
      logic                lst;
      logic                given;
      logic                g_found;
      logic                g_full;
   } stim_row_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action   = ACT_NONE;
   logic [LETTER_W-1:0] req_letter   = '0;
   logic                req_last     = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic                rsp_found;
   logic                rsp_full_res;

   // Trie model state.
   logic [NODE_W-1:0] kid_tab [NODES*ALPHABET];
   bit                mark_tab [NODES];
   int                pool_used;
   int                walk_at;
   bit                walk_miss;
   bit                walk_over;

   word_result_type pending_results[$];
   word_result_type rsp_want;
   int              mismatch_count = 0;
   int              letters_sent   = 0;
   int              burst_left     = 0;
   int              stall_mode     = STALL_NONE;
   int              stall_span     = 0;

   // Word under construction and a ring of recently inserted words.
   logic [LETTER_W-1:0] word_buf [MAX_WORD];
   int                  word_len;
   logic [LETTER_W-1:0] vocab_ltr [VOCAB_SIZE][MAX_WORD];
   int                  vocab_len [VOCAB_SIZE];
   int                  vocab_n;

   stim_row_type dir_table [DIR_ROWS] = '{
      '{ACT_FIND,   5'd0,  1'b1, 1'b1, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0},
      '{ACT_FIND,   5'd0,  1'b1, 1'b1, 1'b1, 1'b0},
      '{ACT_INSERT, 5'd25, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ACT_FIND,   5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ACT_FIND,   5'd25, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_FIND,   5'd25, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd31, 1'b1, 1'b1, 1'b0, 1'b1},
      '{ACT_FIND,   5'd26, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ACT_NONE,   5'd31, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd16, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_FIND,   5'd17, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd30, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd2,  1'b1, 1'b0, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd30, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ACT_FIND,   5'd0,  1'b1, 1'b0, 1'b0, 1'b0},
      '{ACT_FIND,   5'd16, 1'b1, 1'b0, 1'b0, 1'b0},
      '{ACT_CLEAR,  5'd31, 1'b1, 1'b1, 1'b0, 1'b0},
      '{ACT_FIND,   5'd0,  1'b1, 1'b1, 1'b0, 1'b0},
      '{ACT_INSERT, 5'd0,  1'b1, 1'b1, 1'b0, 1'b0}
   };

   trie_word_store_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_letter   (req_letter),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_found    (rsp_found),
      .rsp_full_res (rsp_full_res)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic blank_row(input int n);
      for (int i = 0; i < ALPHABET; i++) kid_tab[n*ALPHABET + i] = '0;
      mark_tab[n] = 1'b0;
   endtask

   task automatic clear_trie();
      blank_row(0);
      pool_used = 1;
      walk_at   = 0;
      walk_miss = 1'b0;
      walk_over = 1'b0;
   endtask

   // Advance the trie model by one letter request and tell whether it ends a word.
   task automatic step_trie(input action_type act, input logic [LETTER_W-1:0] ltr,
                            input logic lst, output bit has_rsp, output bit r_found,
                            output bit r_full);
      int child;
      has_rsp = 1'b0;
      r_found = 1'b0;
      r_full  = 1'b0;
      if (act == ACT_CLEAR) begin
         clear_trie();
         return;
      end
      if (act == ACT_NONE) return;
      if (act == ACT_INSERT) begin
         // Walk down, allocating a blank node wherever a child is missing and the pool has room.
         if (!walk_over) begin
            if (ltr >= ALPHABET) begin
               walk_over = 1'b1;
            end else begin
               child = int'(kid_tab[walk_at*ALPHABET + ltr]);
               if (child == 0) begin
                  if (pool_used >= NODES) begin
                     walk_over = 1'b1;
                  end else begin
                     child = pool_used;
                     pool_used++;
                     blank_row(child);
                     kid_tab[walk_at*ALPHABET + ltr] = child[NODE_W-1:0];
                     walk_miss = 1'b1;
                     walk_at = child;
                  end
               end else begin
                  walk_at = child;
               end
            end
         end
         if (lst) begin
            if (walk_over) begin
               r_full = 1'b1;
            end else begin
               r_found = !walk_miss && mark_tab[walk_at];
               mark_tab[walk_at] = 1'b1;
            end
         end
      end else begin
         // A find letter sees an overflowed walk as a miss.
         if (walk_over) walk_miss = 1'b1;
         if (!walk_miss) begin
            if (ltr >= ALPHABET) begin
               walk_miss = 1'b1;
            end else begin
               child = int'(kid_tab[walk_at*ALPHABET + ltr]);
               if (child == 0) walk_miss = 1'b1;
               else walk_at = child;
            end
         end
         if (lst) r_found = !walk_miss && mark_tab[walk_at];
      end
      if (lst) begin
         has_rsp   = 1'b1;
         walk_at   = 0;
         walk_miss = 1'b0;
         walk_over = 1'b0;
      end
   endtask

   // Sender pacing: bursts of back-to-back requests, then a random gap.
   task automatic pace_sender();
      int gap;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Offer one request, wait for its acceptance and record what it should produce.
   task automatic send_letter(input action_type act, input logic [LETTER_W-1:0] ltr,
                              input logic lst, input bit given, input bit g_found,
                              input bit g_full);
      bit has_rsp;
      bit p_found;
      bit p_full;
      req_valid  <= 1'b1;
      req_action <= act;
      req_letter <= ltr;
      req_last   <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_trie(act, ltr, lst, has_rsp, p_found, p_full);
      if (has_rsp) begin
         if (given) pending_results.push_back('{found: g_found, full_res: g_full});
         else pending_results.push_back('{found: p_found, full_res: p_full});
      end
      if (act != ACT_NONE) letters_sent++;
      pace_sender();
   endtask

   // Send the word in word_buf; a mixed word picks insert or find per letter.
   task automatic send_word(input action_type act, input bit mixed);
      action_type a;
      for (int i = 0; i < word_len; i++) begin
         a = act;
         if (mixed) a = $urandom_range(0, 1) ? ACT_FIND : ACT_INSERT;
         send_letter(a, word_buf[i], i == word_len - 1, 1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic make_word(input int lo, input int hi);
      word_len = $urandom_range(lo, hi);
      for (int i = 0; i < word_len; i++)
         word_buf[i] = LETTER_W'($urandom_range(0, ALPHABET - 1));
   endtask

   task automatic save_word();
      int slot;
      slot = vocab_n % VOCAB_SIZE;
      for (int i = 0; i < word_len; i++) vocab_ltr[slot][i] = word_buf[i];
      vocab_len[slot] = word_len;
      vocab_n++;
   endtask

   task automatic load_word(input int slot);
      word_len = vocab_len[slot];
      for (int i = 0; i < word_len; i++) word_buf[i] = vocab_ltr[slot][i];
   endtask

   // Response checking and the receiver's own stall pattern.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response arrived with no word waiting on one");
         end else begin
            rsp_want = pending_results.pop_front();
            if (rsp_found !== rsp_want.found)
               report_mismatch($sformatf("found is %b, expected %b",
                                         rsp_found, rsp_want.found));
            if (rsp_full_res !== rsp_want.full_res)
               report_mismatch($sformatf("full_res is %b, expected %b",
                                         rsp_full_res, rsp_want.full_res));
         end
      end
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_SPARSE);
         stall_span <= $urandom_range(8, 60);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_ready <= 1'b1;
         STALL_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   initial begin : stimulus
      int pick;
      int extra;
      int avail;
      int stop_at;
      clear_trie();
      vocab_n = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: empty store, extremes, out-of-range letters, mixed words, clear.
      foreach (dir_table[i])
         send_letter(dir_table[i].act, dir_table[i].ltr, dir_table[i].lst,
                     dir_table[i].given, dir_table[i].g_found, dir_table[i].g_full);

      // Random words, mostly built on earlier words so finds hit and prefixes share.
      stop_at = letters_sent + RANDOM_LETTERS;
      while (letters_sent < stop_at) begin
         avail = (vocab_n < VOCAB_SIZE) ? vocab_n : VOCAB_SIZE;
         if (avail != 0 && $urandom_range(0, 1)) begin
            load_word($urandom_range(0, avail - 1));
            word_len = $urandom_range(1, word_len);
            extra = $urandom_range(0, 3);
            for (int k = 0; k < extra && word_len < 12; k++) begin
               word_buf[word_len] = LETTER_W'($urandom_range(0, ALPHABET - 1));
               word_len++;
            end
         end else begin
            make_word(1, 6);
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            save_word();
            send_word(ACT_INSERT, 1'b0);
         end else if (pick < 65) begin
            if (avail != 0) load_word($urandom_range(0, avail - 1));
            send_word(ACT_FIND, 1'b0);
         end else if (pick < 80) begin
            send_word(ACT_FIND, 1'b0);
         end else if (pick < 88) begin
            send_word(ACT_INSERT, 1'b1);
         end else if (pick < 94) begin
            // Broken word: one letter outside the alphabet.
            word_buf[$urandom_range(0, word_len - 1)] = LETTER_W'($urandom_range(ALPHABET, 31));
            send_word($urandom_range(0, 1) ? ACT_FIND : ACT_INSERT, 1'b0);
         end else if (pick < 97) begin
            send_letter(ACT_CLEAR, LETTER_W'($urandom_range(0, 31)),
                        1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
            vocab_n = 0;
         end else begin
            send_letter(ACT_NONE, LETTER_W'($urandom_range(0, 31)),
                        1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
         end
      end

      // Drain outstanding responses, then give the block time to show strays.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
rtl/tws_pkg.sv
rtl/trie_word_store_top.sv
bench/trie_word_store_top_tb.sv
